### rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types, register map and constants of the fan level controller.
// ----------------------------------------------------------------------------
package fhc_pkg;

  localparam int unsigned TempW  = 19;
  localparam int unsigned ThrW   = 18;
  localparam int unsigned LevelW = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [TempW-1:0] TempMaxMdeg = 19'd150000;

  // register map, word index
  localparam logic [2:0] RegLowThr  = 3'd0;
  localparam logic [2:0] RegMedThr  = 3'd1;
  localparam logic [2:0] RegHighThr = 3'd2;
  localparam logic [2:0] RegFullThr = 3'd3;
  localparam logic [2:0] RegHyst    = 3'd4;
  localparam logic [2:0] RegSensEn  = 3'd5;

  localparam logic [ThrW-1:0] LowThrRst  = 18'd50000;
  localparam logic [ThrW-1:0] MedThrRst  = 18'd60000;
  localparam logic [ThrW-1:0] HighThrRst = 18'd67500;
  localparam logic [ThrW-1:0] FullThrRst = 18'd75000;
  localparam logic [ThrW-1:0] HystRst    = 18'd5000;
  localparam logic [1:0]      SensEnRst  = 2'd3;

  // fan levels
  localparam logic [LevelW-1:0] LvlOff    = 3'd0;
  localparam logic [LevelW-1:0] LvlLow    = 3'd1;
  localparam logic [LevelW-1:0] LvlMedium = 3'd2;
  localparam logic [LevelW-1:0] LvlHigh   = 3'd3;
  localparam logic [LevelW-1:0] LvlFull   = 3'd4;

  typedef struct packed {
    logic [ThrW-1:0] low_thr;
    logic [ThrW-1:0] med_thr;
    logic [ThrW-1:0] high_thr;
    logic [ThrW-1:0] full_thr;
    logic [ThrW-1:0] hyst;
    logic [1:0]      sens_en;
  } cfg_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_a;
    logic                    temp_a_ok;
    logic signed [TempW-1:0] temp_b;
    logic                    temp_b_ok;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] fan_level;
    logic              level_changed;
    logic              no_reading;
    logic [TempW-1:0]  average_x2;
    logic [1:0]        sensors_used;
  } res_t;

endpackage

### rtl/fhc_in_if.sv
// ----------------------------------------------------------------------------
// fhc_in_if
// Sensor tick channel: two raw readings with their valid flags.
// ----------------------------------------------------------------------------
interface fhc_in_if;
  import fhc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_a;
  logic                    temp_a_ok;
  logic signed [TempW-1:0] temp_b;
  logic                    temp_b_ok;

  modport source (output valid, temp_a, temp_a_ok, temp_b, temp_b_ok, input ready);
  modport sink   (input valid, temp_a, temp_a_ok, temp_b, temp_b_ok, output ready);
endinterface

### rtl/fhc_out_if.sv
// ----------------------------------------------------------------------------
// fhc_out_if
// Result channel: fan level and averaging status of one tick.
// ----------------------------------------------------------------------------
interface fhc_out_if;
  import fhc_pkg::*;

  logic                valid;
  logic                ready;
  logic [LevelW-1:0]   fan_level;
  logic                level_changed;
  logic                no_reading;
  logic [TempW-1:0]    average_x2;
  logic [1:0]          sensors_used;

  modport source (output valid, fan_level, level_changed, no_reading, average_x2,
                  sensors_used, input ready);
  modport sink   (input valid, fan_level, level_changed, no_reading, average_x2,
                  sensors_used, output ready);
endinterface

### rtl/fhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// fhc_cfg_regs
// APB register file holding thresholds, hysteresis and sensor enables.
// ----------------------------------------------------------------------------
module fhc_cfg_regs
  import fhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr  <= LowThrRst;
      cfg_q.med_thr  <= MedThrRst;
      cfg_q.high_thr <= HighThrRst;
      cfg_q.full_thr <= FullThrRst;
      cfg_q.hyst     <= HystRst;
      cfg_q.sens_en  <= SensEnRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegLowThr:  cfg_q.low_thr  <= pwdata[ThrW-1:0];
        RegMedThr:  cfg_q.med_thr  <= pwdata[ThrW-1:0];
        RegHighThr: cfg_q.high_thr <= pwdata[ThrW-1:0];
        RegFullThr: cfg_q.full_thr <= pwdata[ThrW-1:0];
        RegHyst:    cfg_q.hyst     <= pwdata[ThrW-1:0];
        RegSensEn:  cfg_q.sens_en  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegLowThr:  prdata = {{(DataW-ThrW){1'b0}}, cfg_q.low_thr};
      RegMedThr:  prdata = {{(DataW-ThrW){1'b0}}, cfg_q.med_thr};
      RegHighThr: prdata = {{(DataW-ThrW){1'b0}}, cfg_q.high_thr};
      RegFullThr: prdata = {{(DataW-ThrW){1'b0}}, cfg_q.full_thr};
      RegHyst:    prdata = {{(DataW-ThrW){1'b0}}, cfg_q.hyst};
      RegSensEn:  prdata = {{(DataW-2){1'b0}}, cfg_q.sens_en};
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/fhc_level_eval.sv
// ----------------------------------------------------------------------------
// fhc_level_eval
// Validate and average the readings, pick the target level, apply hysteresis.
// ----------------------------------------------------------------------------
module fhc_level_eval
  import fhc_pkg::*;
(
  input  cfg_t              cfg_i,
  input  in_item_t          item_i,
  input  logic [LevelW-1:0] level_i,
  output logic [LevelW-1:0] level_o,
  output res_t              res_o
);

  logic [TempW-1:0]  ta, tb;
  logic              va, vb;
  logic [TempW-1:0]  sum;
  logic [TempW-1:0]  avg2;
  logic [LevelW-1:0] tgt;
  logic [ThrW-1:0]   upper;
  logic [TempW:0]    lhs, rhs;
  logic              take;

  assign ta = item_i.temp_a;
  assign tb = item_i.temp_b;
  assign va = cfg_i.sens_en[0] && item_i.temp_a_ok && (ta <= TempMaxMdeg);
  assign vb = cfg_i.sens_en[1] && item_i.temp_b_ok && (tb <= TempMaxMdeg);

  assign sum  = (va ? ta : '0) + (vb ? tb : '0);
  assign avg2 = (va && vb) ? sum : {sum[TempW-2:0], 1'b0};

  always_comb begin
    if (avg2 >= {cfg_i.full_thr, 1'b0}) begin
      tgt = LvlFull;
    end else if (avg2 >= {cfg_i.high_thr, 1'b0}) begin
      tgt = LvlHigh;
    end else if (avg2 >= {cfg_i.med_thr, 1'b0}) begin
      tgt = LvlMedium;
    end else if (avg2 >= {cfg_i.low_thr, 1'b0}) begin
      tgt = LvlLow;
    end else begin
      tgt = LvlOff;
    end
  end

  always_comb begin
    case (tgt)
      LvlOff:    upper = cfg_i.low_thr;
      LvlLow:    upper = cfg_i.med_thr;
      LvlMedium: upper = cfg_i.high_thr;
      default:   upper = cfg_i.full_thr;
    endcase
  end

  // drop only when avg2 + 2*hyst <= 2*upper
  assign lhs  = {1'b0, avg2} + {1'b0, cfg_i.hyst, 1'b0};
  assign rhs  = {1'b0, upper, 1'b0};
  assign take = (cfg_i.hyst == '0) || (tgt >= level_i) || (lhs <= rhs);

  always_comb begin
    if (!(va || vb)) begin
      level_o             = level_i;
      res_o.fan_level     = level_i;
      res_o.level_changed = 1'b0;
      res_o.no_reading    = 1'b1;
      res_o.average_x2    = '0;
      res_o.sensors_used  = 2'd0;
    end else begin
      level_o             = take ? tgt : level_i;
      res_o.fan_level     = level_o;
      res_o.level_changed = take && (tgt != level_i);
      res_o.no_reading    = 1'b0;
      res_o.average_x2    = avg2;
      res_o.sensors_used  = {1'b0, va} + {1'b0, vb};
    end
  end

endmodule

### rtl/fan_level_hysteresis_controller_top.sv
// ----------------------------------------------------------------------------
// fan_level_hysteresis_controller_top
// Fan level controller with four thresholds and hysteresis on the way down.
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      temp_a, temp_a_ok, temp_b, temp_b_ok
//   out_o     out   valid/ready      fan_level, level_changed, no_reading,
//                                    average_x2, sensors_used
//   APB       in    psel/penable     6 registers at byte address 4*index
//
// One item per cycle sustained while the output is ready.
// The input register feeds the evaluation logic, whose result and next
// level are captured together when the result register is free.
// A stalled output holds one result while one more item waits in the
// input register. Reset clears the level to OFF and empties both stages.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_controller_top
  import fhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  fhc_in_if.sink           in_i,
  fhc_out_if.source        out_o
);

  cfg_t              cfg;
  logic              s1_valid_q;
  in_item_t          s1_item_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic [LevelW-1:0] level_q, level_d;
  res_t              res_d;
  logic              adv;
  logic              in_acc;

  fhc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fhc_level_eval u_eval (
    .cfg_i   (cfg),
    .item_i  (s1_item_q),
    .level_i (level_q),
    .level_o (level_d),
    .res_o   (res_d)
  );

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= LvlOff;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        level_q     <= level_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.temp_a    <= in_i.temp_a;
      s1_item_q.temp_a_ok <= in_i.temp_a_ok;
      s1_item_q.temp_b    <= in_i.temp_b;
      s1_item_q.temp_b_ok <= in_i.temp_b_ok;
    end
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fan_level     = out_res_q.fan_level;
  assign out_o.level_changed = out_res_q.level_changed;
  assign out_o.no_reading    = out_res_q.no_reading;
  assign out_o.average_x2    = out_res_q.average_x2;
  assign out_o.sensors_used  = out_res_q.sensors_used;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlFull)
    else $error("fan level out of range");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(level_q))
    else $error("fan level moved without an item");

  a_result_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_res_q.fan_level == level_q))
    else $error("result level differs from level register");

  a_no_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.no_reading |->
      !out_res_q.level_changed && out_res_q.sensors_used == 2'd0)
    else $error("no reading result carries a change or a sensor count");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q)
    else $error("stalled item dropped from input register");
`endif

endmodule

### bench/fhc_level_checker.sv
// ----------------------------------------------------------------------------
// fhc_level_checker
// Watches the tick and result channels and the register port of the fan
// level controller. Keeps its own copy of the thresholds and the fan level,
// works out the result of every accepted tick and compares each delivered
// result field by field, oldest first. Counts failures for the top.
// ----------------------------------------------------------------------------
module fhc_level_checker
  import fhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  fhc_in_if                tick_i,
  fhc_out_if               res_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  cfg_t              cfg_q;
  logic [LevelW-1:0] level_q;
  res_t              expected_q[$];

  function automatic res_t advance_fan_level(in_item_t tick);
    logic [TempW-1:0]  ta;
    logic [TempW-1:0]  tb;
    logic              use_a;
    logic              use_b;
    longint            avg2;
    longint            lim;
    logic [LevelW-1:0] prev;
    logic [LevelW-1:0] tgt;
    logic [ThrW-1:0]   upper;
    res_t              r;
    ta    = tick.temp_a;
    tb    = tick.temp_b;
    use_a = cfg_q.sens_en[0] && tick.temp_a_ok && (ta <= TempMaxMdeg);
    use_b = cfg_q.sens_en[1] && tick.temp_b_ok && (tb <= TempMaxMdeg);
    prev  = level_q;
    r     = '0;
    if (!use_a && !use_b) begin
      r.fan_level  = level_q;
      r.no_reading = 1'b1;
      return r;
    end
    avg2 = (use_a ? longint'(ta) : 0) + (use_b ? longint'(tb) : 0);
    if (!(use_a && use_b)) avg2 = 2 * avg2;
    if (avg2 >= 2 * longint'(cfg_q.full_thr)) tgt = LvlFull;
    else if (avg2 >= 2 * longint'(cfg_q.high_thr)) tgt = LvlHigh;
    else if (avg2 >= 2 * longint'(cfg_q.med_thr)) tgt = LvlMedium;
    else if (avg2 >= 2 * longint'(cfg_q.low_thr)) tgt = LvlLow;
    else tgt = LvlOff;
    if (cfg_q.hyst != '0 && tgt < prev) begin
      case (tgt)
        LvlOff:    upper = cfg_q.low_thr;
        LvlLow:    upper = cfg_q.med_thr;
        LvlMedium: upper = cfg_q.high_thr;
        default:   upper = cfg_q.full_thr;
      endcase
      lim = 2 * longint'(upper) - 2 * longint'(cfg_q.hyst);
      if (avg2 > lim) tgt = prev;
    end
    level_q         = tgt;
    r.fan_level     = tgt;
    r.level_changed = (tgt != prev);
    r.average_x2    = avg2[TempW-1:0];
    r.sensors_used  = {1'b0, use_a} + {1'b0, use_b};
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t     want;
    in_item_t tick;
    if (!rst_ni) begin
      cfg_q        = '{low_thr: LowThrRst, med_thr: MedThrRst, high_thr: HighThrRst,
                       full_thr: FullThrRst, hyst: HystRst, sens_en: SensEnRst};
      level_q      = LvlOff;
      fail_count_o = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no item pending, expected none actual level %0d",
                   $time, res_i.fan_level);
        end else begin
          want = expected_q.pop_front();
          check_field("fan_level", want.fan_level, res_i.fan_level);
          check_field("level_changed", want.level_changed, res_i.level_changed);
          check_field("no_reading", want.no_reading, res_i.no_reading);
          check_field("average_x2", want.average_x2, res_i.average_x2);
          check_field("sensors_used", want.sensors_used, res_i.sensors_used);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegLowThr:  cfg_q.low_thr  = pwdata[ThrW-1:0];
          RegMedThr:  cfg_q.med_thr  = pwdata[ThrW-1:0];
          RegHighThr: cfg_q.high_thr = pwdata[ThrW-1:0];
          RegFullThr: cfg_q.full_thr = pwdata[ThrW-1:0];
          RegHyst:    cfg_q.hyst     = pwdata[ThrW-1:0];
          RegSensEn:  cfg_q.sens_en  = pwdata[1:0];
          default: ;
        endcase
      end
      if (tick_i.valid && tick_i.ready) begin
        tick = '{temp_a: tick_i.temp_a, temp_a_ok: tick_i.temp_a_ok,
                 temp_b: tick_i.temp_b, temp_b_ok: tick_i.temp_b_ok};
        expected_q.insert(expected_q.size(), advance_fan_level(tick));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### bench/fan_level_hysteresis_controller_top_tb.sv
// ----------------------------------------------------------------------------
// fan_level_hysteresis_controller_top_tb
// Drives sensor ticks and register writes into the fan level controller
// through a series of threshold, hysteresis and sensor enable settings,
// with random gaps on both channels, a long output stall and a pause that
// drains the block. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_controller_top_tb;
  import fhc_pkg::*;

  localparam int unsigned PhaseCount = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int unsigned      fail_count;
  int unsigned      pending_results;
  bit               hold_req = 1'b0;
  bit               no_idle  = 1'b0;
  logic [ThrW-1:0]  level_thr[5];

  fhc_in_if  tick_if ();
  fhc_out_if res_if ();

  fan_level_hysteresis_controller_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_if),
    .out_o   (res_if)
  );

  fhc_level_checker level_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .tick_i       (tick_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= RegHyst) level_thr[idx] = val[ThrW-1:0];
  endtask

  task automatic settle();
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic send_tick(input logic [TempW-1:0] a, input logic a_ok,
                           input logic [TempW-1:0] b, input logic b_ok);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 38) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid     <= 1'b1;
    tick_if.temp_a    <= a;
    tick_if.temp_a_ok <= a_ok;
    tick_if.temp_b    <= b;
    tick_if.temp_b_ok <= b_ok;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [TempW-1:0] pick_temp();
    int spread;
    int t;
    case ($urandom_range(9))
      0: return TempW'($urandom);
      1: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return TempMaxMdeg;
          2:       return TempMaxMdeg + 1'b1;
          3:       return '1;
          4:       return 19'h40000;
          default: return 19'h3FFFF;
        endcase
      end
      2, 3: return TempW'($urandom_range(150000));
      default: begin
        spread = int'(level_thr[RegHyst]) + 2000;
        t = int'(level_thr[$urandom_range(3)]) + int'($urandom_range(2 * spread)) - spread;
        return TempW'(t);
      end
    endcase
  endfunction

  task automatic random_tick();
    logic [TempW-1:0] a;
    logic [TempW-1:0] b;
    a = pick_temp();
    if ($urandom_range(99) < 55) b = a + TempW'($urandom_range(1000)) - TempW'(500);
    else b = pick_temp();
    send_tick(a, $urandom_range(99) < 88, b, $urandom_range(99) < 88);
  endtask

  task automatic set_phase_regs(input int p);
    logic [DataW-1:0] vals[6];
    int unsigned      lo;
    vals = '{LowThrRst, MedThrRst, HighThrRst, FullThrRst, HystRst, SensEnRst};
    case (p)
      1: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3};
      2: vals = '{'1, '1, '1, '1, '1, 32'd3};
      3: begin
        vals[RegHyst]   = 32'd0;
        vals[RegSensEn] = 32'd1;
      end
      4: begin
        vals[RegHyst]   = 32'd150000;
        vals[RegSensEn] = 32'd2;
      end
      5: vals[RegSensEn] = 32'd0;
      6: vals = '{32'd100000, 32'd20000, 32'd140000, 32'd60000, 32'd3000, 32'd3};
      default: begin
        lo                = $urandom_range(20000, 60000);
        vals[RegLowThr]   = lo;
        vals[RegMedThr]   = lo + $urandom_range(20000);
        vals[RegHighThr]  = vals[RegMedThr] + $urandom_range(20000);
        vals[RegFullThr]  = vals[RegHighThr] + $urandom_range(20000);
        vals[RegHyst]     = ($urandom_range(3) == 0) ? 0 : $urandom_range(15000);
        vals[RegSensEn]   = ($urandom_range(1) == 0) ? 3 : $urandom_range(3);
      end
    endcase
    for (int r = RegLowThr; r <= RegSensEn; r++) write_reg(3'(r), vals[r]);
  endtask

  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    tick_if.valid     <= 1'b0;
    tick_if.temp_a    <= '0;
    tick_if.temp_a_ok <= 1'b0;
    tick_if.temp_b    <= '0;
    tick_if.temp_b_ok <= 1'b0;
    level_thr = '{LowThrRst, MedThrRst, HighThrRst, FullThrRst, HystRst};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        settle();
        set_phase_regs(p);
      end
      no_idle = (p == 3);
      if (p == 0) begin
        send_tick(19'd1000, 1'b0, 19'd2000, 1'b0);
        send_tick(19'd0, 1'b1, 19'd0, 1'b1);
        send_tick(TempMaxMdeg, 1'b1, TempMaxMdeg, 1'b1);
        send_tick(19'd72000, 1'b1, 19'd72000, 1'b1);
        send_tick(19'd70000, 1'b1, 19'd70000, 1'b1);
        send_tick(TempMaxMdeg + 1'b1, 1'b1, '1, 1'b1);
        send_tick(19'h40000, 1'b1, 19'h3FFFF, 1'b1);
        send_tick(19'd50000, 1'b1, 19'h3FFFF, 1'b0);
        send_tick(19'd0, 1'b0, TempMaxMdeg, 1'b1);
        send_tick(19'd55000, 1'b1, 19'd64999, 1'b1);
        send_tick(19'd1, 1'b1, 19'd0, 1'b1);
        send_tick(19'd49999, 1'b1, 19'd50000, 1'b1);
        send_tick(19'd45000, 1'b1, 19'd45000, 1'b1);
        send_tick(19'd44999, 1'b1, 19'd45000, 1'b1);
      end
      n_items = (p == 1 || p == 2 || p == 5) ? 40 : 110;
      for (int i = 0; i < n_items; i++) begin
        if (p == 0 && i == 30) hold_req = 1'b1;
        if (p == 6 && i == 50) settle();
        random_tick();
      end
    end
    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/fhc_pkg.sv
rtl/fhc_in_if.sv
rtl/fhc_out_if.sv
rtl/fhc_cfg_regs.sv
rtl/fhc_level_eval.sv
rtl/fan_level_hysteresis_controller_top.sv
bench/fhc_level_checker.sv
bench/fan_level_hysteresis_controller_top_tb.sv
